### design/lpvs_pkg.sv
// Shared types, constants and the pen map for the line-palette video scanout.
// No dependencies; the scanout and the result queue refer to it by scoped names.

package lpvs_pkg;

  // Source store geometry
  localparam int SOURCE_ROWS    = 64;
  localparam int SOURCE_COLUMNS = 128;
  localparam int STORE_DEPTH    = SOURCE_ROWS * SOURCE_COLUMNS;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int CELL_ADDR_W    = 13;
  localparam int SRC_COL_W      = $clog2(SOURCE_COLUMNS);

  // Row indexing: PAL_AW addresses a row, ROW_W also holds SOURCE_ROWS itself
  localparam int PAL_AW = (SOURCE_ROWS > 1) ? $clog2(SOURCE_ROWS) : 1;
  localparam int ROW_W  = $clog2(SOURCE_ROWS + 1);

  // Output line geometry
  localparam int LINE_PIXELS = 2 * SOURCE_COLUMNS;
  localparam int COL_W       = $clog2(LINE_PIXELS);
  localparam int LINE_W      = 9;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(LINE_PIXELS - 1);

  // Columns whose bit 1 selects the row palette
  localparam logic [SRC_COL_W-1:0] PAL_LOW_CELL  = SRC_COL_W'(125);
  localparam logic [SRC_COL_W-1:0] PAL_HIGH_CELL = SRC_COL_W'(126);

  // Register widths and limits
  localparam int REP_W      = 4;
  localparam int HEIGHT_W   = 10;
  localparam int REP_MAX    = 8;
  localparam int HEIGHT_MAX = 512;
  localparam int FULL_W     = $clog2(SOURCE_ROWS * REP_MAX + 1);
  localparam int TOT_W      = (FULL_W > HEIGHT_W) ? FULL_W : HEIGHT_W;
  localparam int REPCNT_W   = 3;

  // Result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [2:0]        colour_index;
    logic [COL_W-1:0]  pixel_column;
    logic [LINE_W-1:0] pixel_line;
    logic              frame_end;
  } result_t;

  // Palette times four plus pixel bits to pen
  function automatic logic [2:0] pen_lookup(input logic [3:0] idx);
    logic [2:0] pen;
    case (idx)
      4'd0:    pen = 3'd0;
      4'd1:    pen = 3'd1;
      4'd2:    pen = 3'd1;
      4'd3:    pen = 3'd1;
      4'd4:    pen = 3'd7;
      4'd5:    pen = 3'd4;
      4'd6:    pen = 3'd2;
      4'd7:    pen = 3'd3;
      4'd8:    pen = 3'd5;
      4'd9:    pen = 3'd4;
      4'd10:   pen = 3'd2;
      4'd11:   pen = 3'd3;
      4'd12:   pen = 3'd6;
      4'd13:   pen = 3'd4;
      4'd14:   pen = 3'd2;
      4'd15:   pen = 3'd3;
      default: pen = 3'd0;
    endcase
    return pen;
  endfunction

endpackage

### design/line_palette_video_scanout.sv
// Line-palette video scanout: 2-bit cell store, per-row palette, one pixel per tick beat.
// Depends on lpvs_pkg, lpvs_ram (cell store and row palette store) and lpvs_out_fifo.
// Path: a tick beat's store read is registered with the read stage, then its pixel goes
// to the result queue. Throughput: one beat per cycle while in_stall is low.
// Reset: a clearing sweep of the cell store (one cell a cycle) holds in_stall high;
// configuration writes are taken throughout. Row palettes are read-modify-written.

module line_palette_video_scanout (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic [lpvs_pkg::CELL_ADDR_W-1:0]    in_cell_address,
  input  logic [1:0]                          in_cell_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_colour_index,
  output logic [lpvs_pkg::COL_W-1:0]          out_pixel_column,
  output logic [lpvs_pkg::LINE_W-1:0]         out_pixel_line,
  output logic                                out_frame_end,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam logic REG_LINE_REPEAT  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Configuration registers
  logic [lpvs_pkg::REP_W-1:0]    line_repeat_r;
  logic [lpvs_pkg::HEIGHT_W-1:0] frame_height_r;

  // Scan counters
  logic [lpvs_pkg::COL_W-1:0]    col_r,     col_nxt;
  logic [lpvs_pkg::LINE_W-1:0]   line_r,    line_nxt;
  logic [lpvs_pkg::ROW_W-1:0]    row_r,     row_nxt;
  logic [lpvs_pkg::REPCNT_W-1:0] rep_cnt_r, rep_cnt_nxt;

  // Clearing sweep
  logic                          clear_r;
  logic [lpvs_pkg::ADDR_W-1:0]   clr_cnt_r;

  // Read stage
  logic                          s1_tick_r;
  logic                          s1_pwr_r;
  logic                          s1_phi_r;
  logic                          s1_pbit_r;
  logic [lpvs_pkg::PAL_AW-1:0]   s1_prow_r;
  logic [lpvs_pkg::COL_W-1:0]    s1_col_r;
  logic [lpvs_pkg::LINE_W-1:0]   s1_line_r;
  logic                          s1_last_r;

  // Palette forwarding
  logic                          fwd_v_r;
  logic [1:0]                    fwd_d_r;

  logic                          cfg_wr;
  logic                          in_acc;
  logic                          tick_acc;
  logic                          wr_acc;

  logic [lpvs_pkg::REP_W-1:0]    rep;
  logic [lpvs_pkg::HEIGHT_W-1:0] height;
  logic [lpvs_pkg::TOT_W-1:0]    full_lines;
  logic [lpvs_pkg::TOT_W-1:0]    total;
  logic                          restart;
  logic [lpvs_pkg::COL_W-1:0]    cur_col;
  logic [lpvs_pkg::LINE_W-1:0]   cur_line;
  logic [lpvs_pkg::ROW_W-1:0]    cur_row;
  logic [lpvs_pkg::REPCNT_W-1:0] cur_rep_cnt;
  logic [lpvs_pkg::REPCNT_W:0]   rep_inc;
  logic                          last;

  logic [lpvs_pkg::ADDR_W+lpvs_pkg::CELL_ADDR_W-1:0] wr_wide;
  logic                          wr_in_range;
  logic [lpvs_pkg::SRC_COL_W-1:0] wr_col;
  logic [lpvs_pkg::PAL_AW-1:0]   wr_row;
  logic                          wr_pal;

  logic                          cell_we;
  logic [lpvs_pkg::ADDR_W-1:0]   cell_waddr;
  logic [1:0]                    cell_wdata;
  logic [lpvs_pkg::ADDR_W-1:0]   cell_raddr;
  logic [1:0]                    cell_rdata;

  logic                          pal_we;
  logic [lpvs_pkg::PAL_AW-1:0]   pal_waddr;
  logic [1:0]                    pal_wdata;
  logic [lpvs_pkg::PAL_AW-1:0]   pal_raddr;
  logic [1:0]                    pal_rdata;
  logic [1:0]                    pal_eff;

  lpvs_pkg::result_t             res;
  lpvs_pkg::result_t             head;
  logic [lpvs_pkg::OUT_CNT_W-1:0] fifo_count;
  logic                          pop;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_repeat_r  <= lpvs_pkg::REP_W'(4);
      frame_height_r <= lpvs_pkg::HEIGHT_W'(256);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LINE_REPEAT:  line_repeat_r  <= pwdata[lpvs_pkg::REP_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[lpvs_pkg::HEIGHT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LINE_REPEAT:  prdata = 32'(line_repeat_r);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  // Accept while not clearing and the result queue plus the read stage leave room
  assign in_stall = clear_r ||
    ((lpvs_pkg::OUT_CNT_W+1)'(fifo_count) + (lpvs_pkg::OUT_CNT_W+1)'(s1_tick_r)
     >= (lpvs_pkg::OUT_CNT_W+1)'(lpvs_pkg::OUT_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign tick_acc = in_acc && in_action;
  assign wr_acc   = in_acc && !in_action;

  // Clamp registers and work out the frame length
  always_comb begin
    if (line_repeat_r == '0) begin
      rep = lpvs_pkg::REP_W'(1);
    end else if (line_repeat_r > lpvs_pkg::REP_W'(lpvs_pkg::REP_MAX)) begin
      rep = lpvs_pkg::REP_W'(lpvs_pkg::REP_MAX);
    end else begin
      rep = line_repeat_r;
    end
    if (frame_height_r == '0) begin
      height = lpvs_pkg::HEIGHT_W'(1);
    end else if (frame_height_r > lpvs_pkg::HEIGHT_W'(lpvs_pkg::HEIGHT_MAX)) begin
      height = lpvs_pkg::HEIGHT_W'(lpvs_pkg::HEIGHT_MAX);
    end else begin
      height = frame_height_r;
    end
    full_lines = lpvs_pkg::TOT_W'(lpvs_pkg::SOURCE_ROWS) * lpvs_pkg::TOT_W'(rep);
    total = (lpvs_pkg::TOT_W'(height) < full_lines) ? lpvs_pkg::TOT_W'(height) : full_lines;
  end

  // Restart check, end-of-frame flag and counter advance
  always_comb begin
    restart = (lpvs_pkg::TOT_W'(line_r) >= total) ||
              (row_r >= lpvs_pkg::ROW_W'(lpvs_pkg::SOURCE_ROWS));
    cur_col     = restart ? '0 : col_r;
    cur_line    = restart ? '0 : line_r;
    cur_row     = restart ? '0 : row_r;
    cur_rep_cnt = restart ? '0 : rep_cnt_r;
    last = (cur_col == lpvs_pkg::LAST_COL) &&
           (lpvs_pkg::TOT_W'(cur_line) + lpvs_pkg::TOT_W'(1) >= total);
    rep_inc = {1'b0, cur_rep_cnt} + 1'b1;

    col_nxt     = col_r;
    line_nxt    = line_r;
    row_nxt     = row_r;
    rep_cnt_nxt = rep_cnt_r;
    if (tick_acc) begin
      if (last) begin
        col_nxt     = '0;
        line_nxt    = '0;
        row_nxt     = '0;
        rep_cnt_nxt = '0;
      end else if (cur_col == lpvs_pkg::LAST_COL) begin
        col_nxt  = '0;
        line_nxt = cur_line + 1'b1;
        if ((lpvs_pkg::REP_W)'(rep_inc) >= rep) begin
          rep_cnt_nxt = '0;
          row_nxt     = cur_row + 1'b1;
        end else begin
          rep_cnt_nxt = rep_inc[lpvs_pkg::REPCNT_W-1:0];
          row_nxt     = cur_row;
        end
      end else begin
        col_nxt     = cur_col + 1'b1;
        line_nxt    = cur_line;
        row_nxt     = cur_row;
        rep_cnt_nxt = cur_rep_cnt;
      end
    end
  end

  // Decode a store write beat
  always_comb begin
    wr_wide     = (lpvs_pkg::ADDR_W+lpvs_pkg::CELL_ADDR_W)'(in_cell_address);
    wr_in_range = wr_wide < (lpvs_pkg::ADDR_W+lpvs_pkg::CELL_ADDR_W)'(lpvs_pkg::STORE_DEPTH);
    wr_col      = wr_wide[lpvs_pkg::SRC_COL_W-1:0];
    wr_row      = lpvs_pkg::PAL_AW'(wr_wide >> lpvs_pkg::SRC_COL_W);
    wr_pal      = wr_in_range &&
                  ((wr_col == lpvs_pkg::PAL_LOW_CELL) || (wr_col == lpvs_pkg::PAL_HIGH_CELL));
  end

  // Cell store ports: sweep during clear, else the write beat
  always_comb begin
    if (clear_r) begin
      cell_we    = 1'b1;
      cell_waddr = clr_cnt_r;
      cell_wdata = '0;
    end else begin
      cell_we    = wr_acc && wr_in_range;
      cell_waddr = lpvs_pkg::ADDR_W'(wr_wide);
      cell_wdata = in_cell_value;
    end
    cell_raddr = lpvs_pkg::ADDR_W'({cur_row[lpvs_pkg::PAL_AW-1:0],
                                    cur_col[lpvs_pkg::COL_W-1:1]});
  end

  // Palette store ports: sweep during clear, else the pending read-modify-write
  always_comb begin
    pal_eff = fwd_v_r ? fwd_d_r : pal_rdata;
    if (clear_r) begin
      pal_we    = {1'b0, clr_cnt_r} < (lpvs_pkg::ADDR_W+1)'(lpvs_pkg::SOURCE_ROWS);
      pal_waddr = lpvs_pkg::PAL_AW'(clr_cnt_r);
      pal_wdata = '0;
    end else begin
      pal_we    = s1_pwr_r;
      pal_waddr = s1_prow_r;
      pal_wdata = s1_phi_r ? {s1_pbit_r, pal_eff[0]} : {pal_eff[1], s1_pbit_r};
    end
    pal_raddr = in_action ? cur_row[lpvs_pkg::PAL_AW-1:0] : wr_row;
  end

  lpvs_ram #(
    .WIDTH (2),
    .DEPTH (lpvs_pkg::STORE_DEPTH)
  ) u_cell_store (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  lpvs_ram #(
    .WIDTH (2),
    .DEPTH (lpvs_pkg::SOURCE_ROWS)
  ) u_pal_store (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  // Control state: clear sweep, counters, read stage flags, forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r   <= 1'b1;
      clr_cnt_r <= '0;
      col_r     <= '0;
      line_r    <= '0;
      row_r     <= '0;
      rep_cnt_r <= '0;
      s1_tick_r <= 1'b0;
      s1_pwr_r  <= 1'b0;
      fwd_v_r   <= 1'b0;
    end else begin
      if (clear_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == lpvs_pkg::ADDR_W'(lpvs_pkg::STORE_DEPTH - 1)) begin
          clear_r <= 1'b0;
        end
      end
      col_r     <= col_nxt;
      line_r    <= line_nxt;
      row_r     <= row_nxt;
      rep_cnt_r <= rep_cnt_nxt;
      s1_tick_r <= tick_acc;
      s1_pwr_r  <= wr_acc && wr_pal;
      fwd_v_r   <= pal_we && (pal_waddr == pal_raddr);
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    fwd_d_r   <= pal_wdata;
    s1_phi_r  <= (wr_col == lpvs_pkg::PAL_HIGH_CELL);
    s1_pbit_r <= in_cell_value[1];
    s1_prow_r <= wr_row;
    s1_col_r  <= cur_col;
    s1_line_r <= cur_line;
    s1_last_r <= last;
  end

  // Form the pixel beat
  always_comb begin
    res.colour_index = lpvs_pkg::pen_lookup({pal_eff, cell_rdata});
    res.pixel_column = s1_col_r;
    res.pixel_line   = s1_line_r;
    res.frame_end    = s1_last_r;
  end

  assign pop = out_valid && !out_stall;

  lpvs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_tick_r),
    .push_data (res),
    .pop       (pop),
    .head      (head),
    .count     (fifo_count)
  );

  assign out_valid        = (fifo_count != '0);
  assign out_colour_index = head.colour_index;
  assign out_pixel_column = head.pixel_column;
  assign out_pixel_line   = head.pixel_line;
  assign out_frame_end    = head.frame_end;

  a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_tick_r && s1_last_r |-> col_r == '0 && line_r == '0 && row_r == '0 &&
                               rep_cnt_r == '0)
    else $error("counters did not wrap after the last pixel of the frame");

  a_idle_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !s1_tick_r && !s1_pwr_r)
    else $error("beat in flight during the clearing sweep");

  a_frame_end_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_pixel_column == lpvs_pkg::LAST_COL)
    else $error("frame end flagged away from the last column");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> row_r <= lpvs_pkg::ROW_W'(lpvs_pkg::SOURCE_ROWS))
    else $error("source row ran past the store");

endmodule

### design/lpvs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; a read of the entry written in the same cycle returns old data.

module lpvs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8192
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/lpvs_out_fifo.sv
// Small result queue between the scan pipeline and the output channel.
// Depends on lpvs_pkg for the result type and queue depth.

module lpvs_out_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  lpvs_pkg::result_t                 push_data,
  input  logic                              pop,
  output lpvs_pkg::result_t                 head,
  output logic [lpvs_pkg::OUT_CNT_W-1:0]    count
);

  lpvs_pkg::result_t                   mem_r [lpvs_pkg::OUT_DEPTH];
  logic [lpvs_pkg::OUT_PTR_W-1:0]      wr_ptr_r;
  logic [lpvs_pkg::OUT_PTR_W-1:0]      rd_ptr_r;
  logic [lpvs_pkg::OUT_CNT_W-1:0]      count_r;

  // Store beat at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r < lpvs_pkg::OUT_CNT_W'(lpvs_pkg::OUT_DEPTH))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("result queue underflow");

endmodule

### test/testbench.sv
// Self-checking bench for line_palette_video_scanout: directed table, then random phases.
// Depends on lpvs_pkg and the scanout RTL; a predictor or the table checks each result beat.

module testbench;
  import lpvs_pkg::*;

  localparam logic       ACT_WRITE        = 1'b0;
  localparam logic       ACT_TICK         = 1'b1;
  localparam logic [2:0] REG_LINE_REPEAT  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;
  localparam int         SETTLE_CYCLES    = 8;
  localparam int         QUIET_LIMIT      = 50000;
  localparam int         REPORT_MAX       = 10;
  localparam int         DIRECTED_ROWS    = 22;

  // Pen per (palette * 4 + cell), entry 0 in the low bits
  localparam logic [47:0] PEN_MAP = {
    3'd3, 3'd2, 3'd4, 3'd6,   // 15..12: light green palette
    3'd3, 3'd2, 3'd4, 3'd5,   // 11..8:  light gray palette
    3'd3, 3'd2, 3'd4, 3'd7,   // 7..4:   light blue palette
    3'd1, 3'd1, 3'd1, 3'd0    // 3..0:   black and white
  };

  localparam result_t NO_PIXEL = '0;

  typedef struct packed {
    logic       act;
    logic [12:0] addr;
    logic [1:0]  val;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_action = 1'b0;
  logic [CELL_ADDR_W-1:0]   in_cell_address = '0;
  logic [1:0]               in_cell_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [2:0]               out_colour_index;
  logic [COL_W-1:0]         out_pixel_column;
  logic [LINE_W-1:0]        out_pixel_line;
  logic                     out_frame_end;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [2:0]               paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  // Predictor state: cell store, scan counters and register copies
  logic [1:0]  cell_mem [0:STORE_DEPTH-1];
  logic [7:0]  scan_col = '0;
  int          scan_line = 0;
  int          scan_row = 0;
  int          row_repeats = 0;
  logic [3:0]  cfg_repeat = 4'd4;
  logic [9:0]  cfg_height = 10'd256;

  result_t     pixel_q [$];
  result_t     want_px;
  stim_row_t   directed_rows [DIRECTED_ROWS];

  bit          src_gaps = 1'b0;
  bit          sink_gaps = 1'b0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int          mismatch_count = 0;
  int          pixel_count = 0;
  int          write_count = 0;
  int          frame_count = 0;
  int          setting_count = 0;

  line_palette_video_scanout u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_cell_address  (in_cell_address),
    .in_cell_value    (in_cell_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_colour_index (out_colour_index),
    .out_pixel_column (out_pixel_column),
    .out_pixel_line   (out_pixel_line),
    .out_frame_end    (out_frame_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #1 clk = ~clk;

  // Work out the pixel for one tick beat and advance the scan counters
  function automatic result_t next_pixel();
    int         rep;
    int         total;
    int         base;
    logic [3:0] idx;
    result_t    px;
    rep = (cfg_repeat == 0) ? 1 : (cfg_repeat > 8) ? 8 : int'(cfg_repeat);
    total = (cfg_height == 0) ? 1 : (cfg_height > 512) ? 512 : int'(cfg_height);
    if (total > SOURCE_ROWS * rep) total = SOURCE_ROWS * rep;
    // restart the frame when a register change left the scan outside it
    if (scan_line >= total || scan_row >= SOURCE_ROWS) begin
      scan_col = '0;
      scan_line = 0;
      scan_row = 0;
      row_repeats = 0;
    end
    base = scan_row * SOURCE_COLUMNS;
    idx = {cell_mem[base + int'(PAL_HIGH_CELL)][1], cell_mem[base + int'(PAL_LOW_CELL)][1],
           cell_mem[base + int'(scan_col[7:1])]};
    px.colour_index = PEN_MAP[idx * 3 +: 3];
    px.pixel_column = scan_col;
    px.pixel_line   = LINE_W'(scan_line);
    px.frame_end    = (scan_col == 8'd255) && (scan_line + 1 >= total);
    if (px.frame_end) begin
      scan_col = '0;
      scan_line = 0;
      scan_row = 0;
      row_repeats = 0;
    end else if (scan_col == 8'd255) begin
      scan_col = '0;
      scan_line++;
      row_repeats++;
      if (row_repeats >= rep) begin
        row_repeats = 0;
        scan_row++;
      end
    end else begin
      scan_col++;
    end
    return px;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatch_count < REPORT_MAX)
      $display("mismatch on %s: got %0d expected %0d (pixel beat %0d)",
               what, got, want, pixel_count);
    mismatch_count++;
  endtask

  // Offer one input beat, hold it until taken, then update the predictor
  task automatic send_beat(input logic act, input logic [12:0] addr, input logic [1:0] val,
                           input bit typed, input result_t want);
    result_t px;
    if (src_gaps && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_cell_address <= addr;
    in_cell_value   <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ACT_TICK) begin
      px = next_pixel();
      pixel_q.push_back(typed ? want : px);
    end else begin
      cell_mem[addr] = val;
      write_count++;
    end
  endtask

  // Drop valid and wait for every pending pixel, then let stray writes settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_LINE_REPEAT) cfg_repeat = data[3:0];
    else if (addr == REG_FRAME_HEIGHT) cfg_height = data[9:0];
  endtask

  // Random beats under one register setting; writes lean towards the row being shown
  task automatic run_phase(input logic [31:0] rep, input logic [31:0] height, input int beats,
                           input int tick_pct, input bit gaps);
    logic [5:0] row;
    logic [6:0] col;
    wait_drained();
    write_reg(REG_LINE_REPEAT, rep);
    write_reg(REG_FRAME_HEIGHT, height);
    setting_count++;
    src_gaps  = gaps;
    sink_gaps = gaps && ($urandom_range(0, 3) != 0);
    for (int n = 0; n < beats; n++) begin
      if ($urandom_range(1, 100) <= tick_pct) begin
        send_beat(ACT_TICK, 13'($urandom), 2'($urandom), 1'b0, NO_PIXEL);
      end else begin
        row = ($urandom_range(0, 1) == 0 && scan_row < SOURCE_ROWS) ? 6'(scan_row)
                                                                    : 6'($urandom_range(0, 63));
        case ($urandom_range(0, 3))
          0:       col = PAL_LOW_CELL;
          1:       col = PAL_HIGH_CELL;
          default: col = 7'($urandom_range(0, 127));
        endcase
        send_beat(ACT_WRITE, {row, col}, 2'($urandom_range(0, 3)), 1'b0, NO_PIXEL);
      end
    end
  endtask

  // Result side stall bursts
  always @(posedge clk) begin
    if (!rst_n || !sink_gaps) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left != 1);
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 19);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each result beat against the oldest expected pixel
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        flag_mismatch("unexpected pixel, column", int'(out_pixel_column), -1);
      end else begin
        want_px = pixel_q.pop_front();
        if (out_colour_index !== want_px.colour_index)
          flag_mismatch("colour_index", int'(out_colour_index), int'(want_px.colour_index));
        if (out_pixel_column !== want_px.pixel_column)
          flag_mismatch("pixel_column", int'(out_pixel_column), int'(want_px.pixel_column));
        if (out_pixel_line !== want_px.pixel_line)
          flag_mismatch("pixel_line", int'(out_pixel_line), int'(want_px.pixel_line));
        if (out_frame_end !== want_px.frame_end)
          flag_mismatch("frame_end", int'(out_frame_end), int'(want_px.frame_end));
        if (want_px.frame_end) frame_count++;
      end
      pixel_count++;
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) cell_mem[i] = 2'd0;

    // Directed table under reset settings: palettes, cell values and address extremes
    directed_rows = '{
      '{ACT_TICK,  13'd0,    2'd0, 1'b1, '{3'd0, 8'd0, 9'd0, 1'b0}},
      '{ACT_WRITE, 13'd0,    2'd3, 1'b0, NO_PIXEL},
      '{ACT_TICK,  13'd0,    2'd0, 1'b1, '{3'd1, 8'd1, 9'd0, 1'b0}},
      '{ACT_WRITE, 13'd126,  2'd2, 1'b0, NO_PIXEL},
      '{ACT_TICK,  13'd0,    2'd0, 1'b0, NO_PIXEL},
      '{ACT_WRITE, 13'd125,  2'd2, 1'b0, NO_PIXEL},
      '{ACT_WRITE, 13'd1,    2'd1, 1'b0, NO_PIXEL},
      '{ACT_TICK,  13'd8191, 2'd3, 1'b0, NO_PIXEL},
      '{ACT_WRITE, 13'd126,  2'd1, 1'b0, NO_PIXEL},
      '{ACT_TICK,  13'd0,    2'd0, 1'b0, NO_PIXEL},
      '{ACT_WRITE, 13'd2,    2'd2, 1'b0, NO_PIXEL},
      '{ACT_TICK,  13'd0,    2'd0, 1'b0, NO_PIXEL},
      '{ACT_WRITE, 13'd8191, 2'd3, 1'b0, NO_PIXEL},
      '{ACT_WRITE, 13'd4096, 2'd1, 1'b0, NO_PIXEL},
      '{ACT_WRITE, 13'd125,  2'd0, 1'b0, NO_PIXEL},
      '{ACT_WRITE, 13'd3,    2'd3, 1'b0, NO_PIXEL},
      '{ACT_TICK,  13'd0,    2'd0, 1'b0, NO_PIXEL},
      '{ACT_TICK,  13'd0,    2'd0, 1'b0, NO_PIXEL},
      '{ACT_WRITE, 13'd0,    2'd0, 1'b0, NO_PIXEL},
      '{ACT_TICK,  13'd0,    2'd0, 1'b0, NO_PIXEL},
      '{ACT_WRITE, 13'd8191, 2'd0, 1'b0, NO_PIXEL},
      '{ACT_TICK,  13'd0,    2'd0, 1'b0, NO_PIXEL}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_beat(directed_rows[i].act, directed_rows[i].addr, directed_rows[i].val,
                directed_rows[i].typed, directed_rows[i].want);

    // Random phases; a setting change can land mid-frame on the running counters
    run_phase(32'd4,  32'd256,  80,  75, 1'b1);
    run_phase(32'd1,  32'd1,    300, 90, 1'b1);
    run_phase(32'd0,  32'd7,    700, 88, 1'b1);
    run_phase(32'd15, 32'd0,    300, 90, 1'b1);
    run_phase(32'd8,  32'd1023, 120, 70, 1'b1);
    run_phase(32'd2,  32'd512,  120, 70, 1'b1);
    run_phase(32'd5,  32'd2,    150, 80, 1'b1);
    run_phase(32'd1,  32'd1,    300, 90, 1'b0);
    wait_drained();

    $display("checked %0d pixel beats and %0d cell writes across %0d register settings",
             pixel_count, write_count, setting_count);
    $display("%0d frame ends seen, %0d mismatches", frame_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
